[hw/rtl/lfuc_pkg.sv]
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared constants and types for the LFU cache table: table geometry,
// operation codes, request and response words, and rank array commands.
// ----------------------------------------------------------------------------
`default_nettype none

package lfuc_pkg;

   // Table geometry.
   localparam int CAPACITY   = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_BITS  = IDX_BITS;
   localparam int OCC_BITS   = $clog2(CAPACITY + 1);
   localparam int CSR_BITS   = 5;
   localparam int CMP_BITS   = (OCC_BITS > CSR_BITS) ? OCC_BITS : CSR_BITS;

   localparam logic [CSR_BITS-1:0]   CSR_RESET = CSR_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // Operation codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Rank array commands.
   localparam logic [1:0] RANK_NONE   = 2'd0;
   localparam logic [1:0] RANK_TOUCH  = 2'd1;
   localparam logic [1:0] RANK_INSERT = 2'd2;

   typedef struct packed {
      logic                       operation;
      logic signed [KEY_BITS-1:0] key;
      logic signed [KEY_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                       hit;
      logic signed [KEY_BITS-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [IDX_BITS-1:0]  slot;
      logic [RANK_BITS-1:0] ref_rank;
   } rank_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/lfu_cache_table.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value cache with least-frequently-used replacement
// and least-recently-used tie-break. One compare unit walks the entries.
// ----------------------------------------------------------------------------
//   Channel   Ports                     Handshake
//   request   start, busy, req_data     taken when start and not busy
//   response  rsp_strobe, rsp_data      one-cycle strobe, cannot be held off
//   config    csr_we, csr_wdata         written when csr_we is high
//
// From acceptance to the response strobe, the scan reads one entry per
// cycle from the entry store through its registered read port, a flush
// state drains the read stage, then the update state applies the update.
// busy stays high through the scan, flush and update; the next word may
// be started in the cycle its predecessor's response is shown.
// Reset clears all entries and sets the capacity in use to 16.
// The receiver cannot stall the response, so nothing is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire lfuc_pkg::req_type                 req_data,
   output logic                                   rsp_strobe,
   output lfuc_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [lfuc_pkg::CSR_BITS-1:0]     csr_wdata
);
   import lfuc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FLUSH  = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   localparam logic [IDX_BITS-1:0] IDX_LAST  = IDX_BITS'(CAPACITY - 1);
   localparam logic [CMP_BITS-1:0] CAP_LIMIT = CMP_BITS'(CAPACITY);

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [CSR_BITS-1:0] cap_ff;
   req_type             req_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;
   logic                accept;

   // Entry store.
   logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
   logic [KEY_BITS-1:0]   value_mem [CAPACITY];
   logic [COUNT_BITS-1:0] count_mem [CAPACITY];

   // Read stage.
   logic                  rd_live_ff;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [KEY_BITS-1:0]   rd_value_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;
   logic                  rd_valid_ff;
   logic [RANK_BITS-1:0]  rd_rank_ff;
   logic                  ra_valid;
   logic [RANK_BITS-1:0]  ra_rank;

   // Scan trackers.
   logic                  match_found_ff, match_found_in;
   logic [IDX_BITS-1:0]   match_idx_ff, match_idx_in;
   logic [KEY_BITS-1:0]   match_value_ff, match_value_in;
   logic [COUNT_BITS-1:0] match_count_ff, match_count_in;
   logic [RANK_BITS-1:0]  match_rank_ff, match_rank_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  vic_found_ff, vic_found_in;
   logic [IDX_BITS-1:0]   vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0] vic_count_ff, vic_count_in;
   logic [RANK_BITS-1:0]  vic_rank_ff, vic_rank_in;

   // Update decisions.
   logic [CMP_BITS-1:0]   cap_ext;
   logic [CMP_BITS-1:0]   cap_eff;
   logic                  do_bump;
   logic                  do_insert;
   logic                  do_evict;
   logic                  wr_en;
   logic                  wr_key_en;
   logic                  wr_value_en;
   logic [IDX_BITS-1:0]   wr_idx;
   logic [COUNT_BITS-1:0] wr_count;
   rank_cmd_type          rank_cmd;
   rsp_type               rsp_in;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CSR_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // Sequencer: scan every entry, drain the read stage, then update.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IDX_BITS'(1);
            if (idx_ff == IDX_LAST) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         rd_live_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rd_live_ff    <= (state_ff == ST_SCAN);
         rsp_strobe_ff <= (state_ff == ST_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_ff <= rsp_in;
      end
   end

   // Entry store: registered read at the scan index, one write port.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= idx_ff;
      rd_key_ff   <= key_mem[idx_ff];
      rd_value_ff <= value_mem[idx_ff];
      rd_count_ff <= count_mem[idx_ff];
      rd_valid_ff <= ra_valid;
      rd_rank_ff  <= ra_rank;
      if (wr_en) begin
         if (wr_key_en) begin
            key_mem[wr_idx] <= req_ff.key;
         end
         if (wr_value_en) begin
            value_mem[wr_idx] <= req_ff.value;
         end
         count_mem[wr_idx] <= wr_count;
      end
   end

   lfuc_rank_array u_rank (
      .clock    (clock),
      .reset    (reset),
      .rank_cmd (rank_cmd),
      .rd_idx   (idx_ff),
      .rd_valid (ra_valid),
      .rd_rank  (ra_rank)
   );

   // Shared compare unit: key match, free slot, occupancy and victim choice.
   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_value_in = match_value_ff;
      match_count_in = match_count_ff;
      match_rank_in  = match_rank_ff;
      occ_in         = occ_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      vic_found_in   = vic_found_ff;
      vic_idx_in     = vic_idx_ff;
      vic_count_in   = vic_count_ff;
      vic_rank_in    = vic_rank_ff;
      if (accept) begin
         match_found_in = 1'b0;
         occ_in         = '0;
         free_found_in  = 1'b0;
         vic_found_in   = 1'b0;
      end else if (rd_live_ff) begin
         if (rd_valid_ff) begin
            occ_in = occ_ff + OCC_BITS'(1);
            if (rd_key_ff == req_ff.key) begin
               match_found_in = 1'b1;
               match_idx_in   = rd_idx_ff;
               match_value_in = rd_value_ff;
               match_count_in = rd_count_ff;
               match_rank_in  = rd_rank_ff;
            end
            if (!vic_found_ff || (rd_count_ff < vic_count_ff) ||
                ((rd_count_ff == vic_count_ff) && (rd_rank_ff > vic_rank_ff))) begin
               vic_found_in = 1'b1;
               vic_idx_in   = rd_idx_ff;
               vic_count_in = rd_count_ff;
               vic_rank_in  = rd_rank_ff;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         vic_found_ff   <= 1'b0;
         occ_ff         <= '0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         vic_found_ff   <= vic_found_in;
         occ_ff         <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff   <= match_idx_in;
      match_value_ff <= match_value_in;
      match_count_ff <= match_count_in;
      match_rank_ff  <= match_rank_in;
      free_idx_ff    <= free_idx_in;
      vic_idx_ff     <= vic_idx_in;
      vic_count_ff   <= vic_count_in;
      vic_rank_ff    <= vic_rank_in;
   end

   // Update decision. An eviction followed by an insert into the victim's
   // slot ages ranks exactly like a touch of the victim.
   assign cap_ext   = CMP_BITS'(cap_ff);
   assign cap_eff   = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
   assign do_bump   = match_found_ff && ((req_ff.operation == OP_GET) || (cap_eff != '0));
   assign do_insert = (req_ff.operation == OP_PUT) && (cap_eff != '0) && !match_found_ff;
   assign do_evict  = (CMP_BITS'(occ_ff) >= cap_eff);

   always_comb begin
      wr_en         = 1'b0;
      wr_key_en     = 1'b0;
      wr_value_en   = 1'b0;
      wr_idx        = match_idx_ff;
      wr_count      = (match_count_ff == COUNT_MAX) ? COUNT_MAX : match_count_ff + COUNT_ONE;
      rank_cmd.op       = RANK_NONE;
      rank_cmd.slot     = match_idx_ff;
      rank_cmd.ref_rank = match_rank_ff;
      if (state_ff == ST_UPDATE) begin
         priority if (do_bump) begin
            wr_en        = 1'b1;
            wr_value_en  = (req_ff.operation == OP_PUT);
            rank_cmd.op  = RANK_TOUCH;
         end else if (do_insert) begin
            wr_en       = 1'b1;
            wr_key_en   = 1'b1;
            wr_value_en = 1'b1;
            wr_count    = COUNT_ONE;
            if (do_evict) begin
               wr_idx            = vic_idx_ff;
               rank_cmd.op       = RANK_TOUCH;
               rank_cmd.slot     = vic_idx_ff;
               rank_cmd.ref_rank = vic_rank_ff;
            end else begin
               wr_idx        = free_idx_ff;
               rank_cmd.op   = RANK_INSERT;
               rank_cmd.slot = free_idx_ff;
            end
         end else begin
         end
      end
   end

   // Response word: a miss or any put reads back zero.
   always_comb begin
      rsp_in.hit        = match_found_ff;
      rsp_in.read_value = ((req_ff.operation == OP_GET) && match_found_ff) ?
                          match_value_ff : '0;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_UPDATE))
      else $error("response strobe without an update cycle");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |-> (rsp_data.read_value == '0))
      else $error("miss returned a nonzero value");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && do_insert && !do_evict) |-> free_found_ff)
      else $error("insert without eviction found no free slot");

   a_victim: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && do_insert && do_evict) |-> vic_found_ff)
      else $error("eviction without a victim");

endmodule

`default_nettype wire

[hw/rtl/lfuc_rank_array.sv]
// ----------------------------------------------------------------------------
// lfuc_rank_array
// Valid bits and recency ranks of all entries. A touch moves one entry to
// rank zero and ages the more recent ones; an insert ages every valid
// entry and fills a free slot at rank zero. All entries update in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuc_rank_array (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lfuc_pkg::rank_cmd_type         rank_cmd,
   input  wire logic [lfuc_pkg::IDX_BITS-1:0]  rd_idx,
   output logic                                rd_valid,
   output logic [lfuc_pkg::RANK_BITS-1:0]      rd_rank
);
   import lfuc_pkg::*;

   logic [CAPACITY-1:0]  valid_ff;
   logic [CAPACITY-1:0]  valid_in;
   logic [RANK_BITS-1:0] rank_ff [CAPACITY];
   logic [RANK_BITS-1:0] rank_in [CAPACITY];

   // Next ranks and valid bits of every entry.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         unique case (rank_cmd.op)
            RANK_TOUCH: begin
               if (valid_ff[i]) begin
                  if (IDX_BITS'(i) == rank_cmd.slot) begin
                     rank_in[i] = '0;
                  end else if (rank_ff[i] < rank_cmd.ref_rank) begin
                     rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                  end
               end
            end
            RANK_INSERT: begin
               if (IDX_BITS'(i) == rank_cmd.slot) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Valid bits clear at reset; ranks are only read for valid entries.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         rank_ff[i] <= rank_in[i];
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];

endmodule

`default_nettype wire
